// ===== rtl/urbp_pkg.sv =====
// ----------------------------------------------------------------------------
// UART ring buffer pair package
// Shared widths, command and result codes, and the transaction types that
// travel between the front and the back of the block.
// ----------------------------------------------------------------------------
package urbp_pkg;

  localparam int DEF_RING_DEPTH       = 64;
  localparam int DEF_HW_TX_FIFO_DEPTH = 32;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 12;
  localparam int SPACE_W = 6;
  localparam int CNT_W   = SPACE_W + 1;
  localparam int KIND_W  = 2;
  localparam int OUTC_W  = 2;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ISR = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PUT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TX  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END = 2'd3;

  localparam logic [OUTC_W-1:0] OUTC_NONE   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_STORED = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_FULL   = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_ERROR  = 2'd3;

  typedef enum logic [1:0] {
    OP_PUT = 2'd0,
    OP_GET = 2'd1,
    OP_ISR = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] value;
    logic              pending;
    logic              err;
    logic [CNT_W-1:0]  space;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ok;
    logic [BYTE_W-1:0] data;
    logic [OUTC_W-1:0] rx_outcome;
    logic              last;
  } res_t;

endpackage

// ===== rtl/urbp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module urbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/urbp_front.sv =====
// ----------------------------------------------------------------------------
// UART ring buffer pair front end
// Accepts commands, decodes them and holds them in a short queue for the
// back end. Unknown commands are accepted and discarded.
// ----------------------------------------------------------------------------
module urbp_front #(
  parameter int HW_TX_FIFO_DEPTH = urbp_pkg::DEF_HW_TX_FIFO_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [urbp_pkg::CMD_W-1:0]   cmd,
  input  logic [urbp_pkg::BYTE_W-1:0]  tx_byte,
  input  logic                         rx_pending,
  input  logic [urbp_pkg::WORD_W-1:0]  rx_word,
  input  logic [urbp_pkg::SPACE_W-1:0] tx_space,
  output logic                         q_valid,
  input  logic                         q_ready,
  output urbp_pkg::cmd_t               q_entry
);

  import urbp_pkg::*;

  cmd_t              q_mem [CQ_DEPTH];
  logic [CQ_AW-1:0]  wr_ptr;
  logic [CQ_AW-1:0]  rd_ptr;
  logic [CQ_CW-1:0]  count;
  cmd_t              dec;
  logic              dec_valid;
  logic              enq;
  logic              deq;
  logic [CNT_W-1:0]  space_ext;
  logic [CNT_W-1:0]  space_cap;

  assign space_ext = {1'b0, tx_space};
  assign space_cap = CNT_W'(HW_TX_FIFO_DEPTH);

  always_comb begin
    dec.op      = OP_PUT;
    dec.value   = tx_byte;
    dec.pending = rx_pending;
    dec.err     = |rx_word[WORD_W-1:BYTE_W];
    dec.space   = (space_ext > space_cap) ? space_cap : space_ext;
    dec_valid   = 1'b1;
    unique case (cmd)
      CMD_PUT: begin
        dec.op = OP_PUT;
      end
      CMD_GET: begin
        dec.op = OP_GET;
      end
      CMD_ISR: begin
        dec.op    = OP_ISR;
        dec.value = rx_word[BYTE_W-1:0];
      end
      default: begin
        dec_valid = 1'b0;
      end
    endcase
  end

  assign full    = (count == CQ_CW'(CQ_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = q_mem[rd_ptr];
  assign enq     = push && !full && dec_valid;
  assign deq     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/urbp_back.sv =====
// ----------------------------------------------------------------------------
// UART ring buffer pair back end
// Owns both rings and carries out one decoded command at a time, placing
// each result transaction in the output register.
// ----------------------------------------------------------------------------
module urbp_back #(
  parameter int RING_DEPTH = urbp_pkg::DEF_RING_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  urbp_pkg::cmd_t q_entry,
  output logic           res_valid,
  input  logic           pop,
  output urbp_pkg::res_t res
);

  import urbp_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int FW = PW + 1;
  localparam int MW = (FW > CNT_W) ? FW : CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_GET   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_END   = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [PW-1:0]     tx_wr_ptr, tx_wr_ptr_next;
  logic [PW-1:0]     tx_rd_ptr, tx_rd_ptr_next;
  logic [FW-1:0]     tx_fill, tx_fill_next;
  logic [PW-1:0]     rx_wr_ptr, rx_wr_ptr_next;
  logic [PW-1:0]     rx_rd_ptr, rx_rd_ptr_next;
  logic [FW-1:0]     rx_fill, rx_fill_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [OUTC_W-1:0] outc, outc_next;
  logic              out_valid, out_valid_next;
  res_t              out, out_next;
  logic              out_free;
  logic              tx_we, tx_re, rx_we, rx_re;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata;
  logic [MW-1:0]     fill_ext, space_ext, drain_ext;
  logic [CNT_W-1:0]  drain_cnt;
  logic              tx_full, rx_full;

  assign out_free  = !out_valid || pop;
  assign res_valid = out_valid;
  assign res       = out;
  assign tx_full   = (tx_fill == FW'(RING_DEPTH));
  assign rx_full   = (rx_fill == FW'(RING_DEPTH));
  assign fill_ext  = MW'(tx_fill);
  assign space_ext = MW'(q_entry.space);
  assign drain_ext = (fill_ext < space_ext) ? fill_ext : space_ext;
  assign drain_cnt = drain_ext[CNT_W-1:0];

  urbp_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr_ptr),
    .wdata (q_entry.value),
    .re    (tx_re),
    .raddr (tx_rd_ptr),
    .rdata (tx_rdata)
  );

  urbp_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr_ptr),
    .wdata (q_entry.value),
    .re    (rx_re),
    .raddr (rx_rd_ptr),
    .rdata (rx_rdata)
  );

  always_comb begin
    state_next     = state;
    tx_wr_ptr_next = tx_wr_ptr;
    tx_rd_ptr_next = tx_rd_ptr;
    tx_fill_next   = tx_fill;
    rx_wr_ptr_next = rx_wr_ptr;
    rx_rd_ptr_next = rx_rd_ptr;
    rx_fill_next   = rx_fill;
    cnt_next       = cnt;
    outc_next      = outc;
    out_valid_next = out_valid && !pop;
    out_next       = out;
    tx_we          = 1'b0;
    tx_re          = 1'b0;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    q_ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        q_ready = out_free;
        if (q_valid && out_free) begin
          unique case (q_entry.op)
            OP_PUT: begin
              out_valid_next = 1'b1;
              out_next       = '{KIND_PUT, !tx_full, q_entry.value, OUTC_NONE, 1'b1};
              if (!tx_full) begin
                tx_we          = 1'b1;
                tx_wr_ptr_next = tx_wr_ptr + 1'b1;
                tx_fill_next   = tx_fill + 1'b1;
              end
            end
            OP_GET: begin
              if (rx_fill == '0) begin
                out_valid_next = 1'b1;
                out_next       = '{KIND_GET, 1'b0, '0, OUTC_NONE, 1'b1};
              end else begin
                rx_re          = 1'b1;
                rx_rd_ptr_next = rx_rd_ptr + 1'b1;
                rx_fill_next   = rx_fill - 1'b1;
                state_next     = S_GET;
              end
            end
            OP_ISR: begin
              if (q_entry.pending && rx_full) begin
                out_valid_next = 1'b1;
                out_next       = '{KIND_END, 1'b0, '0, OUTC_FULL, 1'b1};
              end else if (q_entry.pending && q_entry.err) begin
                out_valid_next = 1'b1;
                out_next       = '{KIND_END, 1'b0, '0, OUTC_ERROR, 1'b1};
              end else begin
                outc_next = OUTC_NONE;
                if (q_entry.pending) begin
                  rx_we          = 1'b1;
                  rx_wr_ptr_next = rx_wr_ptr + 1'b1;
                  rx_fill_next   = rx_fill + 1'b1;
                  outc_next      = OUTC_STORED;
                end
                if (drain_cnt != '0) begin
                  tx_re          = 1'b1;
                  tx_rd_ptr_next = tx_rd_ptr + 1'b1;
                  tx_fill_next   = tx_fill - 1'b1;
                  cnt_next       = drain_cnt - 1'b1;
                  state_next     = S_DRAIN;
                end else begin
                  state_next = S_END;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_GET: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_next       = '{KIND_GET, 1'b1, rx_rdata, OUTC_NONE, 1'b1};
          state_next     = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_next       = '{KIND_TX, 1'b1, tx_rdata, OUTC_NONE, 1'b0};
          if (cnt != '0) begin
            tx_re          = 1'b1;
            tx_rd_ptr_next = tx_rd_ptr + 1'b1;
            tx_fill_next   = tx_fill - 1'b1;
            cnt_next       = cnt - 1'b1;
          end else begin
            state_next = S_END;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_next       = '{KIND_END, 1'b1, '0, outc, 1'b1};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tx_wr_ptr <= '0;
      tx_rd_ptr <= '0;
      tx_fill   <= '0;
      rx_wr_ptr <= '0;
      rx_rd_ptr <= '0;
      rx_fill   <= '0;
      cnt       <= '0;
      outc      <= OUTC_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tx_wr_ptr <= tx_wr_ptr_next;
      tx_rd_ptr <= tx_rd_ptr_next;
      tx_fill   <= tx_fill_next;
      rx_wr_ptr <= rx_wr_ptr_next;
      rx_rd_ptr <= rx_rd_ptr_next;
      rx_fill   <= rx_fill_next;
      cnt       <= cnt_next;
      outc      <= outc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out <= out_next;
  end

`ifndef NO_ASSERTIONS
  a_tx_ptrs: assert property (@(posedge clk) disable iff (rst)
    tx_wr_ptr == PW'(tx_rd_ptr + tx_fill[PW-1:0]))
    else $error("Transmit ring pointers disagree with its fill count.");

  a_rx_ptrs: assert property (@(posedge clk) disable iff (rst)
    rx_wr_ptr == PW'(rx_rd_ptr + rx_fill[PW-1:0]))
    else $error("Receive ring pointers disagree with its fill count.");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    tx_fill <= FW'(RING_DEPTH) && rx_fill <= FW'(RING_DEPTH))
    else $error("A ring fill count exceeds the ring depth.");

  a_end_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_END && out_free) |=> (out_valid && out.kind == KIND_END && out.last))
    else $error("Interrupt end transaction was not issued.");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && out_free) |=> (out_valid && out.kind == KIND_TX && !out.last))
    else $error("Drained byte transaction is malformed.");
`endif

endmodule

// ===== rtl/uart_ring_buffer_pair.sv =====
// ----------------------------------------------------------------------------
// UART ring buffer pair
// Transmit and receive rings between software and a UART, serving put, get
// and interrupt service commands.
//
//   Channel   Handshake           Fields
//   command   push / full         cmd, tx_byte, rx_pending, rx_word, tx_space
//   result    pop / empty         kind, ok, data, rx_outcome, last
//
// A put, a failed get or an interrupt that drops its word ends in the back
// end's idle state; a successful get adds the get state for the registered
// read of the receive ring RAM. Any other interrupt adds the drain state per
// drained byte and then the end state, the drain reading the transmit ring
// RAM once per cycle unless results stall. A two-entry command queue lets
// commands arrive while the back end works. Synchronous reset empties both
// rings at once. A stalled result holds the back end, not the command queue.
// ----------------------------------------------------------------------------
module uart_ring_buffer_pair #(
  parameter int RING_DEPTH       = urbp_pkg::DEF_RING_DEPTH,
  parameter int HW_TX_FIFO_DEPTH = urbp_pkg::DEF_HW_TX_FIFO_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [urbp_pkg::CMD_W-1:0]   cmd,
  input  logic [urbp_pkg::BYTE_W-1:0]  tx_byte,
  input  logic                         rx_pending,
  input  logic [urbp_pkg::WORD_W-1:0]  rx_word,
  input  logic [urbp_pkg::SPACE_W-1:0] tx_space,
  output logic                         empty,
  input  logic                         pop,
  output logic [urbp_pkg::KIND_W-1:0]  kind,
  output logic                         ok,
  output logic [urbp_pkg::BYTE_W-1:0]  data,
  output logic [urbp_pkg::OUTC_W-1:0]  rx_outcome,
  output logic                         last
);

  import urbp_pkg::*;

  logic q_valid;
  logic q_ready;
  cmd_t q_entry;
  logic res_valid;
  res_t res;

  urbp_front #(.HW_TX_FIFO_DEPTH(HW_TX_FIFO_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .tx_byte    (tx_byte),
    .rx_pending (rx_pending),
    .rx_word    (rx_word),
    .tx_space   (tx_space),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry)
  );

  urbp_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .res_valid (res_valid),
    .pop       (pop),
    .res       (res)
  );

  assign empty      = !res_valid;
  assign kind       = res.kind;
  assign ok         = res.ok;
  assign data       = res.data;
  assign rx_outcome = res.rx_outcome;
  assign last       = res.last;

endmodule

// ===== test/tb_uart_ring_buffer_pair.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART ring buffer pair testbench
// Runs a short directed sequence and then filled-ring sequences and random
// command mixes through the block. A scoreboard model of both rings predicts
// every result transaction, and the monitor compares each result field by
// field. The sender idles in bursts, and the receiver stalls and holds off
// long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_uart_ring_buffer_pair;
  import urbp_pkg::*;

  localparam int RING_DEPTH = DEF_RING_DEPTH;
  localparam int HW_DEPTH   = DEF_HW_TX_FIFO_DEPTH;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int LIMIT      = 500000;
  localparam int DRAIN_WAIT = 80;
  localparam int MAX_PRINTS = 40;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  tx_byte;
    logic               rx_pending;
    logic [WORD_W-1:0]  rx_word;
    logic [SPACE_W-1:0] tx_space;
  } ring_cmd_t;

  logic               clk;
  logic               rst        = 1'b1;
  logic               push       = 1'b0;
  logic               full;
  logic [CMD_W-1:0]   cmd        = '0;
  logic [BYTE_W-1:0]  tx_byte    = '0;
  logic               rx_pending = 1'b0;
  logic [WORD_W-1:0]  rx_word    = '0;
  logic [SPACE_W-1:0] tx_space   = '0;
  logic               empty;
  logic               pop        = 1'b0;
  logic [KIND_W-1:0]  kind;
  logic               ok;
  logic [BYTE_W-1:0]  data;
  logic [OUTC_W-1:0]  rx_outcome;
  logic               last;

  ring_cmd_t   cmd_q[$];
  ring_cmd_t   cur_cmd;
  res_t        expected_q[$];
  res_t        want;

  logic [BYTE_W-1:0] tx_ring [RING_DEPTH];
  logic [BYTE_W-1:0] rx_ring [RING_DEPTH];
  logic [PTR_W-1:0]  tx_wr = '0, tx_rd = '0, rx_wr = '0, rx_rd = '0;
  int unsigned       tx_cnt = 0, rx_cnt = 0;

  int unsigned cycle_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned accepted_cnt = 0, result_cnt = 0, drained_cnt = 0;
  int unsigned put_full_cnt = 0, get_empty_cnt = 0, drop_full_cnt = 0, drop_err_cnt = 0;
  int          burst_left = 0, gap_left = 0, stall_left = 0;
  logic        free_run = 1'b0;
  int unsigned hold_cnt = 0;
  logic        hold_off = 1'b0;

  uart_ring_buffer_pair dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .tx_byte    (tx_byte),
    .rx_pending (rx_pending),
    .rx_word    (rx_word),
    .tx_space   (tx_space),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .ok         (ok),
    .data       (data),
    .rx_outcome (rx_outcome),
    .last       (last)
  );

  function automatic ring_cmd_t mk_cmd(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
                                       input logic p, input logic [WORD_W-1:0] w,
                                       input logic [SPACE_W-1:0] s);
    ring_cmd_t r;
    r.cmd        = c;
    r.tx_byte    = b;
    r.rx_pending = p;
    r.rx_word    = w;
    r.tx_space   = s;
    return r;
  endfunction

  function automatic res_t mk_res(input logic [KIND_W-1:0] k, input logic o,
                                  input logic [BYTE_W-1:0] d, input logic [OUTC_W-1:0] oc,
                                  input logic l);
    res_t r;
    r.kind       = k;
    r.ok         = o;
    r.data       = d;
    r.rx_outcome = oc;
    r.last       = l;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] clean_word();
    return {4'h0, 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [SPACE_W-1:0] pick_space();
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 6));
  endfunction

  task automatic report_mismatch(input string what);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
  endtask

  task automatic predict_ring_response(input ring_cmd_t c);
    int unsigned       room;
    logic [OUTC_W-1:0] outc;
    case (c.cmd)
      CMD_PUT: begin
        if (tx_cnt >= RING_DEPTH) begin
          expected_q.push_back(mk_res(KIND_PUT, 1'b0, c.tx_byte, OUTC_NONE, 1'b1));
          put_full_cnt++;
        end else begin
          tx_ring[tx_wr] = c.tx_byte;
          tx_wr = tx_wr + 1'b1;
          tx_cnt++;
          expected_q.push_back(mk_res(KIND_PUT, 1'b1, c.tx_byte, OUTC_NONE, 1'b1));
        end
      end
      CMD_GET: begin
        if (rx_cnt == 0) begin
          expected_q.push_back(mk_res(KIND_GET, 1'b0, '0, OUTC_NONE, 1'b1));
          get_empty_cnt++;
        end else begin
          expected_q.push_back(mk_res(KIND_GET, 1'b1, rx_ring[rx_rd], OUTC_NONE, 1'b1));
          rx_rd = rx_rd + 1'b1;
          rx_cnt--;
        end
      end
      CMD_ISR: begin
        outc = OUTC_NONE;
        if (c.rx_pending && rx_cnt >= RING_DEPTH) begin
          expected_q.push_back(mk_res(KIND_END, 1'b0, '0, OUTC_FULL, 1'b1));
          drop_full_cnt++;
        end else if (c.rx_pending && c.rx_word[WORD_W-1:BYTE_W] != '0) begin
          expected_q.push_back(mk_res(KIND_END, 1'b0, '0, OUTC_ERROR, 1'b1));
          drop_err_cnt++;
        end else begin
          if (c.rx_pending) begin
            rx_ring[rx_wr] = c.rx_word[BYTE_W-1:0];
            rx_wr = rx_wr + 1'b1;
            rx_cnt++;
            outc = OUTC_STORED;
          end
          room = (c.tx_space > HW_DEPTH) ? HW_DEPTH : c.tx_space;
          while (tx_cnt != 0 && room != 0) begin
            expected_q.push_back(mk_res(KIND_TX, 1'b1, tx_ring[tx_rd], OUTC_NONE, 1'b0));
            tx_rd = tx_rd + 1'b1;
            tx_cnt--;
            room--;
            drained_cnt++;
          end
          expected_q.push_back(mk_res(KIND_END, 1'b1, '0, outc, 1'b1));
        end
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt,
               expected_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      hold_off <= 1'b0;
    end else begin
      hold_cnt <= hold_cnt + 1;
      hold_off <= (hold_cnt >= 250 && hold_cnt < 650) || (hold_cnt >= 1800 && hold_cnt < 2100);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_ring_response(cur_cmd);
        accepted_cnt++;
      end
      if (!(push && full)) begin
        if (gap_left > 0 || cmd_q.size() == 0) begin
          push <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          cur_cmd = cmd_q.pop_front();
          cmd        <= cur_cmd.cmd;
          tx_byte    <= cur_cmd.tx_byte;
          rx_pending <= cur_cmd.rx_pending;
          rx_word    <= cur_cmd.rx_word;
          tx_space   <= cur_cmd.tx_space;
          push       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 40);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        result_cnt++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d data %0h", kind, data));
        end else begin
          want = expected_q.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                      result_cnt, kind, want.kind));
          if (ok !== want.ok)
            report_mismatch($sformatf("result %0d ok %0d, expected %0d",
                                      result_cnt, ok, want.ok));
          if (data !== want.data)
            report_mismatch($sformatf("result %0d data %0h, expected %0h",
                                      result_cnt, data, want.data));
          if (rx_outcome !== want.rx_outcome)
            report_mismatch($sformatf("result %0d rx_outcome %0d, expected %0d",
                                      result_cnt, rx_outcome, want.rx_outcome));
          if (last !== want.last)
            report_mismatch($sformatf("result %0d last %0d, expected %0d",
                                      result_cnt, last, want.last));
        end
      end
      if ($urandom_range(0, 149) == 0) free_run = ~free_run;
      if (stall_left > 0) stall_left--;
      else if (!free_run && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 7);
      pop <= !hold_off && stall_left == 0;
    end
  end

  initial begin
    int n;
    int seg;
    int len;

    cmd_q.push_back(mk_cmd(CMD_GET, 8'h00, 1'b0, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b0, 12'h000, 6'd5));
    cmd_q.push_back(mk_cmd(CMD_PUT, 8'h00, 1'b0, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_PUT, 8'hff, 1'b1, 12'hfff, 6'd63));
    cmd_q.push_back(mk_cmd(CMD_PUT, 8'ha5, 1'b0, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b1, 12'h0ff, 6'd63));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b1, 12'h100, 6'd10));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b1, 12'h800, 6'd10));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'hff, 1'b1, 12'hfff, 6'd63));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b1, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_GET, 8'hff, 1'b1, 12'hfff, 6'd63));
    cmd_q.push_back(mk_cmd(CMD_GET, 8'h00, 1'b0, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_GET, 8'h00, 1'b0, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_PUT, 8'h5a, 1'b0, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b0, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b0, 12'h000, 6'd1));
    cmd_q.push_back(mk_cmd(CMD_NOP, 8'($urandom_range(0, 255)), 1'b1,
                           12'($urandom_range(0, 4095)), 6'($urandom_range(0, 63))));
    cmd_q.push_back(mk_cmd(CMD_NOP, 8'hff, 1'b1, 12'hfff, 6'd63));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b0, 12'hf00, 6'd32));
    cmd_q.push_back(mk_cmd(CMD_PUT, 8'($urandom_range(0, 255)), 1'b0, 12'h000, 6'd0));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b1, 12'h0ab, 6'd33));
    cmd_q.push_back(mk_cmd(CMD_GET, 8'h00, 1'b0, 12'h000, 6'd0));

    for (int i = 0; i < RING_DEPTH + 1; i++)
      cmd_q.push_back(mk_cmd(CMD_PUT, 8'($urandom_range(0, 255)), 1'b0, clean_word(), 6'd0));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b1, clean_word(), 6'd32));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b0, clean_word(), 6'd63));
    for (int i = 0; i < RING_DEPTH + 1; i++)
      cmd_q.push_back(mk_cmd(CMD_ISR, 8'($urandom_range(0, 255)), 1'b1, clean_word(), 6'd0));
    cmd_q.push_back(mk_cmd(CMD_ISR, 8'h00, 1'b1, 12'hfff, 6'd0));
    for (int i = 0; i < RING_DEPTH + 1; i++)
      cmd_q.push_back(mk_cmd(CMD_GET, 8'($urandom_range(0, 255)), 1'b0, clean_word(), 6'd0));

    n = 0;
    while (n < 120) begin
      seg = $urandom_range(0, 4);
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        case (seg)
          0: cmd_q.push_back(mk_cmd(CMD_PUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                    12'($urandom_range(0, 4095)), pick_space()));
          1: cmd_q.push_back(mk_cmd(CMD_GET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                    12'($urandom_range(0, 4095)), pick_space()));
          2: cmd_q.push_back(mk_cmd(CMD_ISR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                    ($urandom_range(0, 5) == 0) ?
                                      {4'($urandom_range(1, 15)), 8'($urandom_range(0, 255))} :
                                      clean_word(),
                                    pick_space()));
          default: cmd_q.push_back(mk_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                          1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                                          6'($urandom_range(0, 63))));
        endcase
        n++;
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || push) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));

    $display("Ran %0d commands giving %0d results, %0d of them bytes drained to the transmitter.",
             accepted_cnt, result_cnt, drained_cnt);
    $display("Saw %0d puts to a full ring, %0d gets from an empty ring, %0d full and %0d flagged drops.",
             put_full_cnt, get_empty_cnt, drop_full_cnt, drop_err_cnt);
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", error_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
